FILE: rtl/three_phase_spwm_compare_macros.svh
// Assertion helpers for the checker file.
`ifndef THREE_PHASE_SPWM_COMPARE_MACROS_SVH
`define THREE_PHASE_SPWM_COMPARE_MACROS_SVH

// Combinational or same-cycle implication, sampled on the rising clock edge.
`define SPWM_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("spwm check failed");

// Antecedent this cycle, consequent in the following cycle.
`define SPWM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("spwm check failed");

`endif

FILE: rtl/tpspwm_pkg.sv
`default_nettype none

package tpspwm_pkg;

	localparam int TABLE_LEN   = 150;
	localparam int SINE_POINTS = 150;
	localparam int IDX_W       = 8;
	localparam int IDX_DEPTH   = 1 << IDX_W;
	localparam int SAMPLE_W    = 15;
	localparam int D_W         = 14;
	localparam int HALF_W      = 16;
	localparam int ACC_W       = 2 * HALF_W;
	localparam int S_LSB       = 15;
	localparam int CNT_W       = 4;
	localparam int CFG_IDX_W   = 1;
	localparam int NUM_PHASES  = 3;

	localparam logic [SAMPLE_W-1:0] SINE_MID   = 15'd16384;
	localparam logic [HALF_W-1:0]   FULL_SCALE = 16'd32767;
	localparam logic [HALF_W-1:0]   GAIN_ONE   = 16'd32768;

	localparam logic [HALF_W-1:0] PERIOD_RST = 16'd1200;
	localparam logic [HALF_W-1:0] GAIN_RST   = 16'd32768;

	localparam logic [IDX_W-1:0] IDX_RST_A = IDX_W'(0);
	localparam logic [IDX_W-1:0] IDX_RST_B = IDX_W'(TABLE_LEN / 3);
	localparam logic [IDX_W-1:0] IDX_RST_C = IDX_W'((2 * TABLE_LEN) / 3);
	localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(TABLE_LEN - 1);

	localparam logic [CFG_IDX_W-1:0] REG_CARRIER_PERIOD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_GAIN   = 1'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GAIN,
		ST_LEVEL,
		ST_SCALE,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic mul_step;
		logic mul_sel;
		logic level_set;
		logic div_step;
	} lane_ctrl_t;

	typedef logic [SAMPLE_W-1:0] sine_rom_t [SINE_POINTS];
	typedef logic [SAMPLE_W-1:0] sample_map_t [IDX_DEPTH];

	localparam sine_rom_t SINE_ROM = '{
		15'h4000, 15'h42AE, 15'h455B, 15'h4805, 15'h4AAC, 15'h4D4E, 15'h4FEA, 15'h527F,
		15'h550C, 15'h578F, 15'h5A08, 15'h5C74, 15'h5ED5, 15'h6127, 15'h636A, 15'h659E,
		15'h67C0, 15'h69D1, 15'h6BCF, 15'h6DB9, 15'h6F8F, 15'h714F, 15'h72FA, 15'h748D,
		15'h7609, 15'h776C, 15'h78B7, 15'h79E8, 15'h7AFF, 15'h7BFB, 15'h7CDD, 15'h7DA3,
		15'h7E4E, 15'h7EDD, 15'h7F4F, 15'h7FA5, 15'h7FDF, 15'h7FFB, 15'h7FFB, 15'h7FDF,
		15'h7FA5, 15'h7F4F, 15'h7EDD, 15'h7E4E, 15'h7DA3, 15'h7CDD, 15'h7BFB, 15'h7AFF,
		15'h79E8, 15'h78B7, 15'h776C, 15'h7609, 15'h748D, 15'h72FA, 15'h714F, 15'h6F8F,
		15'h6DB9, 15'h6BCF, 15'h69D1, 15'h67C0, 15'h659E, 15'h636A, 15'h6127, 15'h5ED5,
		15'h5C74, 15'h5A08, 15'h578F, 15'h550C, 15'h527F, 15'h4FEA, 15'h4D4E, 15'h4AAC,
		15'h4805, 15'h455B, 15'h42AE, 15'h4000, 15'h3D52, 15'h3AA5, 15'h37FB, 15'h3554,
		15'h32B2, 15'h3016, 15'h2D81, 15'h2AF4, 15'h2871, 15'h25F8, 15'h238C, 15'h212B,
		15'h1ED9, 15'h1C96, 15'h1A62, 15'h1840, 15'h162F, 15'h1431, 15'h1247, 15'h1071,
		15'h0EB1, 15'h0D06, 15'h0B73, 15'h09F7, 15'h0894, 15'h0749, 15'h0618, 15'h0501,
		15'h0405, 15'h0323, 15'h025D, 15'h01B2, 15'h0123, 15'h00B1, 15'h005B, 15'h0021,
		15'h0005, 15'h0005, 15'h0021, 15'h005B, 15'h00B1, 15'h0123, 15'h01B2, 15'h025D,
		15'h0323, 15'h0405, 15'h0501, 15'h0618, 15'h0749, 15'h0894, 15'h09F7, 15'h0B73,
		15'h0D06, 15'h0EB1, 15'h1071, 15'h1247, 15'h1431, 15'h162F, 15'h1840, 15'h1A62,
		15'h1C96, 15'h1ED9, 15'h212B, 15'h238C, 15'h25F8, 15'h2871, 15'h2AF4, 15'h2D81,
		15'h3016, 15'h32B2, 15'h3554, 15'h37FB, 15'h3AA5, 15'h3D52
	};

	// Index to sample, resampled onto TABLE_LEN points; out-of-range reads entry 0.
	function automatic sample_map_t build_sample_map();
		sample_map_t m;
		int pos;
		for (int i = 0; i < IDX_DEPTH; i++) begin
			pos = 0;
			if (i < TABLE_LEN) begin
				pos = (i * SINE_POINTS) / TABLE_LEN;
				if (pos >= SINE_POINTS) begin
					pos = 0;
				end
			end
			m[i] = SINE_ROM[pos];
		end
		return m;
	endfunction

	localparam sample_map_t SAMPLE_MAP = build_sample_map();

endpackage

`default_nettype wire

FILE: rtl/tpspwm_lane.sv
`default_nettype none

module tpspwm_lane (
	input  wire logic                                 clk,
	input  wire tpspwm_pkg::lane_ctrl_t               ctrl,
	input  wire logic [tpspwm_pkg::IDX_W-1:0]         idx,
	input  wire logic [tpspwm_pkg::HALF_W-1:0]        gain,
	input  wire logic [tpspwm_pkg::HALF_W-1:0]        period,
	output logic      [tpspwm_pkg::HALF_W-1:0]        compare
);

	localparam int HW = tpspwm_pkg::HALF_W;
	localparam int ACC_W_HI = tpspwm_pkg::ACC_W - 1;

	logic [tpspwm_pkg::ACC_W-1:0]    p_q;
	logic                            hi_q;
	logic [tpspwm_pkg::D_W-1:0]      d_q;

	logic [tpspwm_pkg::SAMPLE_W-1:0] sample;
	logic                            sample_hi;
	logic [tpspwm_pkg::SAMPLE_W-1:0] diff_full;
	logic [HW-1:0]                   mcand;
	logic [HW:0]                     mul_sum;
	logic [tpspwm_pkg::D_W-1:0]      scaled;
	logic [tpspwm_pkg::SAMPLE_W-1:0] level;
	logic [HW-1:0]                   div_t;
	logic                            div_ge;
	logic [HW-1:0]                   div_rem;

	always_comb begin
		sample    = tpspwm_pkg::SAMPLE_MAP[idx];
		sample_hi = sample > tpspwm_pkg::SINE_MID;
		diff_full = sample_hi ? (sample - tpspwm_pkg::SINE_MID)
		                      : (tpspwm_pkg::SINE_MID - sample);

		// shift-add multiply, multiplier held in the low half, LSB first
		mcand   = ctrl.mul_sel ? period : HW'(d_q);
		mul_sum = {1'b0, p_q[ACC_W_HI:HW]} + {1'b0, (p_q[0] ? mcand : '0)};

		scaled = p_q[tpspwm_pkg::S_LSB +: tpspwm_pkg::D_W];
		level  = hi_q ? (tpspwm_pkg::SINE_MID + tpspwm_pkg::SAMPLE_W'(scaled))
		              : (tpspwm_pkg::SINE_MID - tpspwm_pkg::SAMPLE_W'(scaled));

		// restoring divide by full scale, one quotient bit per step
		div_t   = {p_q[ACC_W_HI-1:HW], p_q[HW-1]};
		div_ge  = div_t >= tpspwm_pkg::FULL_SCALE;
		div_rem = div_ge ? (div_t - tpspwm_pkg::FULL_SCALE) : div_t;
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			p_q  <= {{HW{1'b0}}, gain};
			hi_q <= sample_hi;
			d_q  <= diff_full[tpspwm_pkg::D_W-1:0];
		end else if (ctrl.mul_step) begin
			p_q <= {mul_sum, p_q[HW-1:1]};
		end else if (ctrl.level_set) begin
			p_q <= tpspwm_pkg::ACC_W'(level);
		end else if (ctrl.div_step) begin
			p_q <= {div_rem, p_q[HW-2:0], div_ge};
		end
	end

	assign compare = p_q[HW-1:0];

endmodule

`default_nettype wire

FILE: rtl/three_phase_spwm_compare.sv
// Three-phase sine PWM compare generator.
// Input channel (in_valid/in_ready, field tick): a transfer with tick set
// starts one sample; a transfer with tick clear is taken and does nothing.
// Output channel (out_valid/out_ready): compare_a/b/c for the three phases,
// held in an output register until the transfer completes.
// Config: cfg_we/cfg_index/cfg_data write carrier_period (0) and
// voltage_gain (1, Q1.15, capped at 1.0); write only while idle.
// Each phase runs in its own bit-serial lane: 16 steps of shift-add for
// the gain, one step to form the level, 16 steps of shift-add by the
// period and 16 steps of restoring division by 32767.
// A tick transfer is taken only in idle, so one sample is in flight at a
// time; it goes through the three 16-step serial passes, the level step
// and the output step before out_valid rises.
// in_ready is high whenever no sample is in flight, also while a result
// waits; a finished sample waits in the done state if the previous result
// has not been taken.
// Reset: indices to 0, 50, 100; period 1200; gain 1.0; output empty.
`default_nettype none

module three_phase_spwm_compare (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic                                  tick,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic      [tpspwm_pkg::HALF_W-1:0]         compare_a,
	output logic      [tpspwm_pkg::HALF_W-1:0]         compare_b,
	output logic      [tpspwm_pkg::HALF_W-1:0]         compare_c,
	input  wire logic                                  cfg_we,
	input  wire logic [tpspwm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [tpspwm_pkg::HALF_W-1:0]         cfg_data
);

	localparam int NP = tpspwm_pkg::NUM_PHASES;

	tpspwm_pkg::state_t                state_q, state_d;
	logic [tpspwm_pkg::CNT_W-1:0]      cnt_q;
	logic [tpspwm_pkg::HALF_W-1:0]     period_q;
	logic [tpspwm_pkg::HALF_W-1:0]     gain_q;
	logic [tpspwm_pkg::IDX_W-1:0]      idx_q [NP];
	logic                              out_valid_q;
	logic [tpspwm_pkg::HALF_W-1:0]     cmp_q [NP];

	tpspwm_pkg::lane_ctrl_t            ctrl;
	logic                              start;
	logic                              stepping;
	logic                              last_step;
	logic                              out_load;
	logic [tpspwm_pkg::HALF_W-1:0]     gain_sat;
	logic [tpspwm_pkg::HALF_W-1:0]     lane_cmp [NP];

	assign gain_sat  = (gain_q > tpspwm_pkg::GAIN_ONE) ? tpspwm_pkg::GAIN_ONE : gain_q;
	assign last_step = &cnt_q;

	always_comb begin
		state_d  = state_q;
		ctrl     = '0;
		in_ready = 1'b0;
		stepping = 1'b0;
		out_load = 1'b0;
		start    = 1'b0;
		unique case (state_q)
			tpspwm_pkg::ST_IDLE: begin
				in_ready  = 1'b1;
				start     = in_valid & tick;
				ctrl.load = start;
				if (start) begin
					state_d = tpspwm_pkg::ST_GAIN;
				end
			end
			tpspwm_pkg::ST_GAIN: begin
				ctrl.mul_step = 1'b1;
				stepping      = 1'b1;
				if (last_step) begin
					state_d = tpspwm_pkg::ST_LEVEL;
				end
			end
			tpspwm_pkg::ST_LEVEL: begin
				ctrl.level_set = 1'b1;
				state_d        = tpspwm_pkg::ST_SCALE;
			end
			tpspwm_pkg::ST_SCALE: begin
				ctrl.mul_step = 1'b1;
				ctrl.mul_sel  = 1'b1;
				stepping      = 1'b1;
				if (last_step) begin
					state_d = tpspwm_pkg::ST_DIV;
				end
			end
			tpspwm_pkg::ST_DIV: begin
				ctrl.div_step = 1'b1;
				stepping      = 1'b1;
				if (last_step) begin
					state_d = tpspwm_pkg::ST_DONE;
				end
			end
			tpspwm_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = tpspwm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tpspwm_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tpspwm_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= stepping ? cnt_q + 1'b1 : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= tpspwm_pkg::PERIOD_RST;
			gain_q   <= tpspwm_pkg::GAIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tpspwm_pkg::REG_CARRIER_PERIOD: period_q <= cfg_data;
				tpspwm_pkg::REG_VOLTAGE_GAIN:   gain_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q[0] <= tpspwm_pkg::IDX_RST_A;
			idx_q[1] <= tpspwm_pkg::IDX_RST_B;
			idx_q[2] <= tpspwm_pkg::IDX_RST_C;
		end else if (start) begin
			for (int k = 0; k < NP; k++) begin
				idx_q[k] <= (idx_q[k] >= tpspwm_pkg::IDX_LAST) ? '0 : idx_q[k] + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			for (int k = 0; k < NP; k++) begin
				cmp_q[k] <= lane_cmp[k];
			end
		end
	end

	for (genvar g = 0; g < NP; g++) begin : g_lane
		tpspwm_lane u_lane (
			.clk     (clk),
			.ctrl    (ctrl),
			.idx     (idx_q[g]),
			.gain    (gain_sat),
			.period  (period_q),
			.compare (lane_cmp[g])
		);
	end

	assign out_valid = out_valid_q;
	assign compare_a = cmp_q[0];
	assign compare_b = cmp_q[1];
	assign compare_c = cmp_q[2];

endmodule

`default_nettype wire

FILE: rtl/tpspwm_checker.sv
`default_nettype none
`include "three_phase_spwm_compare_macros.svh"

module tpspwm_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              in_valid,
	input wire logic                              in_ready,
	input wire logic                              tick,
	input wire logic                              out_valid,
	input wire logic                              out_ready,
	input wire logic [tpspwm_pkg::HALF_W-1:0]     compare_a,
	input wire logic [tpspwm_pkg::HALF_W-1:0]     compare_b,
	input wire logic [tpspwm_pkg::HALF_W-1:0]     compare_c
);

	// stalled result holds
	`SPWM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(compare_a) && $stable(compare_b) && $stable(compare_c))

	// a tick transfer makes the block busy
	`SPWM_ASSERT_NEXT(a_tick_busy, clk, arst_n, in_valid && in_ready && tick, !in_ready)

	// a transfer without tick leaves the block idle
	`SPWM_ASSERT_NEXT(a_idle_stays, clk, arst_n, in_valid && in_ready && !tick, in_ready)

	// a new result only comes out of a busy cycle
	`SPWM_ASSERT(a_result_busy, clk, arst_n, $rose(out_valid) |-> !$past(in_ready))

endmodule

bind three_phase_spwm_compare tpspwm_checker u_tpspwm_checker (.*);

`default_nettype wire
